// File: rtl/ccc_pkg.sv
// Package for the calendar clock counter: constants, types and day-rollover helper.
`default_nettype none
package ccc_pkg;

  localparam int unsigned MsPerSecondDefault = 1000;

  localparam int unsigned MsW     = 16;
  localparam int unsigned ElapsedW = 12;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonW    = 4;
  localparam int unsigned YearW   = 8;

  localparam logic [SecW:0]  SecLimit   = (SecW+1)'(60);
  localparam logic [MinW:0]  MinLimit   = (MinW+1)'(60);
  localparam logic [HourW:0] HourLimit  = (HourW+1)'(24);
  localparam logic [MonW:0]  MonLimit   = (MonW+1)'(13);
  localparam logic [DayW:0]  DayLimFeb  = (DayW+1)'(29);
  localparam logic [DayW:0]  DayLim30   = (DayW+1)'(31);
  localparam logic [DayW:0]  DayLim31   = (DayW+1)'(32);

  localparam logic [MonW-1:0] MonFeb = MonW'(2);
  localparam logic [MonW-1:0] MonApr = MonW'(4);
  localparam logic [MonW-1:0] MonJun = MonW'(6);
  localparam logic [MonW-1:0] MonSep = MonW'(9);
  localparam logic [MonW-1:0] MonNov = MonW'(11);

  typedef enum logic {
    KIND_ADVANCE = 1'b0,
    KIND_LOAD    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SecW-1:0]  second;
    logic [MinW-1:0]  minute;
    logic [HourW-1:0] hour;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } cal_time_t;

  typedef struct packed {
    kind_e               kind;
    logic [ElapsedW-1:0] elapsed_ms;
    cal_time_t           set_time;
  } cal_req_t;

  // true when the incremented day runs past the end of the month
  function automatic logic day_overflows(logic [MonW-1:0] mon, logic [DayW:0] day);
    logic ovf;
    if (mon == MonFeb) begin
      ovf = (day >= DayLimFeb);
    end else if (mon == MonApr || mon == MonJun || mon == MonSep || mon == MonNov) begin
      ovf = (day >= DayLim30);
    end else begin
      ovf = (day >= DayLim31);
    end
    return ovf;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ccc_if.sv
// Request and response channel interfaces of the calendar clock counter.
`default_nettype none
interface ccc_req_if;
  import ccc_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ElapsedW-1:0] elapsed_ms;
  logic [SecW-1:0]     set_second;
  logic [MinW-1:0]     set_minute;
  logic [HourW-1:0]    set_hour;
  logic [DayW-1:0]     set_day;
  logic [MonW-1:0]     set_month;
  logic [YearW-1:0]    set_year;

  modport source (
    output valid, kind, elapsed_ms, set_second, set_minute, set_hour, set_day,
           set_month, set_year,
    input  ready
  );
  modport sink (
    input  valid, kind, elapsed_ms, set_second, set_minute, set_hour, set_day,
           set_month, set_year,
    output ready
  );
endinterface

interface ccc_rsp_if;
  import ccc_pkg::*;
  logic             valid;
  logic             ready;
  logic [SecW-1:0]  second;
  logic [MinW-1:0]  minute;
  logic [HourW-1:0] hour;
  logic [DayW-1:0]  day;
  logic [MonW-1:0]  month;
  logic [YearW-1:0] year;
  logic [MsW-1:0]   leftover_ms;

  modport source (
    output valid, second, minute, hour, day, month, year, leftover_ms,
    input  ready
  );
  modport sink (
    input  valid, second, minute, hour, day, month, year, leftover_ms,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/calendar_clock_counter.sv
// Calendar clock counter top level: request register, calendar update, response register.
//
// Usage:
//   req channel: kind 0 adds elapsed_ms to the millisecond accumulator (saturating
//   at 65535) and takes at most one second from it; kind 1 loads all counters and
//   clears the accumulator. rsp channel: one response per request with the time
//   and the leftover milliseconds after that request.
//   Path: an accepted request is held in the request register, and its response
//   in the response register until it is taken. Throughput: one request per cycle
//   while responses are taken; the calendar update is a single add, compare and
//   increment ripple between those registers.
//   Stall: while a response waits unaccepted, the request register still takes
//   one request; after that req.ready drops until rsp.ready returns.
//   Reset: rst_ni clears the counters, the accumulator and both valid flags;
//   no response is pending after reset.
`default_nettype none
module calendar_clock_counter #(
  parameter int unsigned MS_PER_SECOND = ccc_pkg::MsPerSecondDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ccc_req_if.sink   req,
  ccc_rsp_if.source rsp
);
  import ccc_pkg::*;

  localparam logic [MsW-1:0] MsPerSec = MsW'(MS_PER_SECOND);

  logic      in_valid_q;
  cal_req_t  in_q;
  logic      in_adv;

  cal_time_t time_q, time_d;
  logic [MsW-1:0] ms_q, ms_d;

  logic      out_valid_q;
  cal_time_t out_time_q;
  logic [MsW-1:0] out_ms_q;

  logic [MsW:0]    sum;
  logic [MsW-1:0]  sat;
  logic [SecW:0]   sec_inc;
  logic [MinW:0]   min_inc;
  logic [HourW:0]  hour_inc;
  logic [DayW:0]   day_inc;
  logic [MonW:0]   mon_inc;
  cal_time_t       ticked;

  assign in_adv    = in_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !in_valid_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.ready) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_q.kind       <= kind_e'(req.kind);
      in_q.elapsed_ms <= req.elapsed_ms;
      in_q.set_time   <= '{second: req.set_second, minute: req.set_minute,
                           hour: req.set_hour, day: req.set_day,
                           month: req.set_month, year: req.set_year};
    end
  end

  always_comb begin
    sec_inc  = {1'b0, time_q.second} + 1'b1;
    min_inc  = {1'b0, time_q.minute} + 1'b1;
    hour_inc = {1'b0, time_q.hour} + 1'b1;
    day_inc  = {1'b0, time_q.day} + 1'b1;
    mon_inc  = {1'b0, time_q.month} + 1'b1;
    ticked   = time_q;
    if (sec_inc < SecLimit) begin
      ticked.second = sec_inc[SecW-1:0];
    end else begin
      ticked.second = '0;
      if (min_inc < MinLimit) begin
        ticked.minute = min_inc[MinW-1:0];
      end else begin
        ticked.minute = '0;
        if (hour_inc < HourLimit) begin
          ticked.hour = hour_inc[HourW-1:0];
        end else begin
          ticked.hour = '0;
          if (!day_overflows(time_q.month, day_inc)) begin
            ticked.day = day_inc[DayW-1:0];
          end else begin
            ticked.day = DayW'(1);
            if (mon_inc < MonLimit) begin
              ticked.month = mon_inc[MonW-1:0];
            end else begin
              ticked.month = MonW'(1);
              ticked.year  = time_q.year + 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    sum    = {1'b0, ms_q} + {{(MsW+1-ElapsedW){1'b0}}, in_q.elapsed_ms};
    sat    = sum[MsW] ? '1 : sum[MsW-1:0];
    time_d = time_q;
    ms_d   = ms_q;
    unique case (in_q.kind)
      KIND_ADVANCE: begin
        if (sat >= MsPerSec) begin
          ms_d   = sat - MsPerSec;
          time_d = ticked;
        end else begin
          ms_d = sat;
        end
      end
      KIND_LOAD: begin
        ms_d   = '0;
        time_d = in_q.set_time;
      end
      default: begin
        ms_d   = ms_q;
        time_d = time_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      ms_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        time_q <= time_d;
        ms_q   <= ms_d;
      end
      if (in_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_time_q <= time_d;
      out_ms_q   <= ms_d;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.second      = out_time_q.second;
  assign rsp.minute      = out_time_q.minute;
  assign rsp.hour        = out_time_q.hour;
  assign rsp.day         = out_time_q.day;
  assign rsp.month       = out_time_q.month;
  assign rsp.year        = out_time_q.year;
  assign rsp.leftover_ms = out_ms_q;

endmodule
`default_nettype wire

// File: rtl/ccc_checker.sv
// Port-level checker for the calendar clock counter and its bind.
`default_nettype none
module ccc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_ready,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [ccc_pkg::SecW-1:0]  rsp_second,
  input wire logic [ccc_pkg::MsW-1:0]   rsp_leftover_ms
);
  import ccc_pkg::*;

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_second) && $stable(rsp_leftover_ms))
    else $error("stalled response changed");

  // requests are refused only while the response is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_valid && !rsp_ready) |-> req_ready)
    else $error("request not taken while output free");

  // nothing pending right after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_second      (rsp.second),
  .rsp_leftover_ms (rsp.leftover_ms)
);
`default_nettype wire

// File: sim/calendar_clock_counter_tb.sv
// Testbench for the calendar clock counter: random and directed requests checked by a predictor.
`timescale 1ns / 100ps
module calendar_clock_counter_tb;
  import ccc_pkg::*;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned ItemsPerPhase = 400;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned RunLimitNs    = 2_000_000;
  localparam int unsigned TimeW         = $bits(cal_time_t);

  typedef struct packed {
    cal_time_t      now;
    logic [MsW-1:0] ms;
  } clock_reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ccc_req_if req_ch ();
  ccc_rsp_if rsp_ch ();

  calendar_clock_counter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  cal_req_t       clock_req_q[$];
  clock_reading_t expected_time_q[$];

  cal_req_t       next_req;
  cal_req_t       taken_req;
  clock_reading_t got;
  clock_reading_t want;

  cal_time_t      cal_now = '0;
  logic [MsW-1:0] cal_ms  = '0;

  logic        req_taken = 1'b0;
  logic        hold_off  = 1'b0;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned sent_n = 0;
  int unsigned seen_n = 0;
  int unsigned mismatches = 0;
  event        hold_start;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned month_length(logic [MonW-1:0] mo);
    case (mo)
      MonFeb: return 28;
      MonApr, MonJun, MonSep, MonNov: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic string reading_str(clock_reading_t r);
    return $sformatf("mon=%0d day=%0d %0d:%0d:%0d year=%0d ms=%0d", r.now.month, r.now.day,
                     r.now.hour, r.now.minute, r.now.second, r.now.year, r.ms);
  endfunction

  // one second forward, rippling up through the calendar
  task automatic tick_second();
    logic [SecW:0]  s;
    logic [MinW:0]  m;
    logic [HourW:0] h;
    logic [DayW:0]  d;
    logic [MonW:0]  mo;
    s = {1'b0, cal_now.second} + 1'b1;
    if (s < 60) begin
      cal_now.second = s[SecW-1:0];
    end else begin
      cal_now.second = '0;
      m = {1'b0, cal_now.minute} + 1'b1;
      if (m < 60) begin
        cal_now.minute = m[MinW-1:0];
      end else begin
        cal_now.minute = '0;
        h = {1'b0, cal_now.hour} + 1'b1;
        if (h < 24) begin
          cal_now.hour = h[HourW-1:0];
        end else begin
          cal_now.hour = '0;
          d = {1'b0, cal_now.day} + 1'b1;
          if (d <= month_length(cal_now.month)) begin
            cal_now.day = d[DayW-1:0];
          end else begin
            cal_now.day = DayW'(1);
            mo = {1'b0, cal_now.month} + 1'b1;
            if (mo < 13) begin
              cal_now.month = mo[MonW-1:0];
            end else begin
              cal_now.month = MonW'(1);
              cal_now.year  = cal_now.year + 1'b1;
            end
          end
        end
      end
    end
  endtask

  task automatic apply_clock_req(input cal_req_t r);
    logic [MsW:0] sum;
    if (r.kind == KIND_LOAD) begin
      cal_ms  = '0;
      cal_now = r.set_time;
    end else begin
      sum = {1'b0, cal_ms} + (MsW+1)'(r.elapsed_ms);
      if (sum > {1'b0, {MsW{1'b1}}}) begin
        sum = {1'b0, {MsW{1'b1}}};
      end
      cal_ms = sum[MsW-1:0];
      if (cal_ms >= MsPerSecondDefault) begin
        cal_ms = cal_ms - MsW'(MsPerSecondDefault);
        tick_second();
      end
    end
  endtask

  task automatic push_advance(input int unsigned ms);
    cal_req_t r;
    r.kind       = KIND_ADVANCE;
    r.elapsed_ms = ElapsedW'(ms);
    r.set_time   = TimeW'({$urandom, $urandom});
    clock_req_q.push_back(r);
  endtask

  task automatic push_load(input int unsigned s, input int unsigned m, input int unsigned h,
                           input int unsigned d, input int unsigned mo, input int unsigned y);
    cal_req_t r;
    r.kind            = KIND_LOAD;
    r.elapsed_ms      = ElapsedW'($urandom);
    r.set_time.second = SecW'(s);
    r.set_time.minute = MinW'(m);
    r.set_time.hour   = HourW'(h);
    r.set_time.day    = DayW'(d);
    r.set_time.month  = MonW'(mo);
    r.set_time.year   = YearW'(y);
    clock_req_q.push_back(r);
  endtask

  task automatic queue_directed();
    push_advance(0);
    push_advance(4095);
    push_load(63, 63, 31, 31, 15, 255);
    clock_req_q[$].elapsed_ms = 12'hfff;
    push_advance(1000);
    push_load(59, 59, 23, 28, 2, 255);
    push_advance(999);
    push_advance(1);
    push_load(59, 59, 23, 30, 4, 7);
    push_advance(1000);
    push_load(59, 59, 23, 31, 12, 255);
    push_advance(1000);
    push_load(59, 59, 23, 30, 6, 1);
    push_advance(1000);
    push_load(59, 59, 23, 31, 0, 2);
    push_advance(1000);
    push_load(59, 59, 23, 30, 9, 3);
    push_advance(1000);
    push_load(59, 59, 23, 30, 11, 4);
    push_advance(1000);
    push_load(59, 59, 23, 31, 1, 0);
    push_advance(1000);
    push_load(62, 10, 5, 3, 3, 9);
    push_advance(1000);
    push_load(0, 0, 0, 0, 0, 0);
  endtask

  task automatic queue_random_reqs(input int unsigned n);
    cal_req_t    r;
    int unsigned pick;
    int unsigned burst_left;
    burst_left = 0;
    repeat (n) begin
      r.kind       = KIND_ADVANCE;
      r.elapsed_ms = ElapsedW'($urandom);
      r.set_time   = TimeW'({$urandom, $urandom});
      if (burst_left != 0) begin
        // large steps back to back drive the accumulator into saturation
        r.elapsed_ms = 12'hfff;
        burst_left--;
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) begin
          burst_left   = $urandom_range(40, 20);
          r.elapsed_ms = 12'hfff;
        end else if (pick < 10) begin
          r.kind = KIND_LOAD;
          case ($urandom_range(2))
            0: ;
            1: begin
              r.set_time.second = SecW'($urandom_range(59, 57));
              r.set_time.minute = MinW'(59);
              r.set_time.hour   = HourW'(23);
              r.set_time.day    = DayW'($urandom_range(31, 26));
            end
            default: begin
              r.set_time.second = SecW'($urandom_range(59));
              r.set_time.minute = MinW'($urandom_range(59));
              r.set_time.hour   = HourW'($urandom_range(23));
              r.set_time.day    = DayW'($urandom_range(31, 1));
              r.set_time.month  = MonW'($urandom_range(12, 1));
            end
          endcase
        end else if (pick < 40) begin
          r.elapsed_ms = ElapsedW'($urandom_range(999));
        end else if (pick < 58) begin
          r.elapsed_ms = ElapsedW'(1000);
        end else if (pick < 70) begin
          r.elapsed_ms = ElapsedW'($urandom_range(1100, 1000));
        end
      end
      clock_req_q.push_back(r);
    end
  endtask

  // request driver and response ready, both updated on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        if (clock_req_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_req = clock_req_q.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.kind       <= next_req.kind;
          req_ch.elapsed_ms <= next_req.elapsed_ms;
          req_ch.set_second <= next_req.set_time.second;
          req_ch.set_minute <= next_req.set_time.minute;
          req_ch.set_hour   <= next_req.set_time.hour;
          req_ch.set_day    <= next_req.set_time.day;
          req_ch.set_month  <= next_req.set_time.month;
          req_ch.set_year   <= next_req.set_time.year;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps going
  always begin
    @(hold_start);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // monitor: predict on request accept, check on response accept
  always @(posedge clk_i) begin
    req_taken <= rst_ni && req_ch.valid && req_ch.ready;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_n <= seen_n + 1;
        got.now.second = rsp_ch.second;
        got.now.minute = rsp_ch.minute;
        got.now.hour   = rsp_ch.hour;
        got.now.day    = rsp_ch.day;
        got.now.month  = rsp_ch.month;
        got.now.year   = rsp_ch.year;
        got.ms         = rsp_ch.leftover_ms;
        if (expected_time_q.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t: response with none expected: %s", $realtime, reading_str(got));
          end
          mismatches++;
        end else begin
          want = expected_time_q.pop_front();
          if (got.now.second !== want.now.second || got.now.minute !== want.now.minute ||
              got.now.hour !== want.now.hour || got.now.day !== want.now.day ||
              got.now.month !== want.now.month || got.now.year !== want.now.year ||
              got.ms !== want.ms) begin
            if (mismatches < ReportLimit) begin
              $display("%0t: time mismatch: expected %s, got %s", $realtime,
                       reading_str(want), reading_str(got));
            end
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        sent_n <= sent_n + 1;
        taken_req.kind            = kind_e'(req_ch.kind);
        taken_req.elapsed_ms      = req_ch.elapsed_ms;
        taken_req.set_time.second = req_ch.set_second;
        taken_req.set_time.minute = req_ch.set_minute;
        taken_req.set_time.hour   = req_ch.set_hour;
        taken_req.set_time.day    = req_ch.set_day;
        taken_req.set_time.month  = req_ch.set_month;
        taken_req.set_time.year   = req_ch.set_year;
        apply_clock_req(taken_req);
        expected_time_q.push_back({cal_now, cal_ms});
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    sender_idle_pct   = 0;
    stall_pct         = 0;
    req_ch.valid      = 1'b0;
    req_ch.kind       = 1'b0;
    req_ch.elapsed_ms = '0;
    req_ch.set_second = '0;
    req_ch.set_minute = '0;
    req_ch.set_hour   = '0;
    req_ch.set_day    = '0;
    req_ch.set_month  = '0;
    req_ch.set_year   = '0;
    rsp_ch.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 57; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 57; end
        default: begin sender_idle_pct = 9; stall_pct = 9; end
      endcase
      if (phase == 0) begin
        queue_directed();
      end
      queue_random_reqs(ItemsPerPhase);
      if (phase == 0) begin
        -> hold_start;
      end
      while (clock_req_q.size() != 0 || req_ch.valid || sent_n != seen_n) begin
        @(posedge clk_i);
      end
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/ccc_pkg.sv
rtl/ccc_if.sv
rtl/calendar_clock_counter.sv
rtl/ccc_checker.sv
sim/calendar_clock_counter_tb.sv
